@@ design/mlfq_pkg.sv @@
// Shared types and constants for the multilevel feedback queue scheduler.
// Holds the request and result structs and the sizing constants.
// It depends on nothing else.
`default_nettype none

package mlfq_pkg;

	// Sizing of the scheduler.
	localparam int NUM_LEVELS = 3;
	localparam int MAX_TASKS  = 16;

	// Field widths, which are fixed by the interface.
	localparam int TASK_W  = 4;
	localparam int LEVEL_W = 2;
	localparam int QUANT_W = 8;
	localparam int WORD_W  = 32;

	// Derived widths for the queue pointers, the fill counts and the queue store.
	localparam int PTR_W     = $clog2(MAX_TASKS);
	localparam int CNT_W     = $clog2(MAX_TASKS + 1);
	localparam int RAM_DEPTH = NUM_LEVELS * MAX_TASKS;
	localparam int RAM_AW    = $clog2(RAM_DEPTH);

	// Configuration register indexes.
	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] REG_QUANTUM0 = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_QUANTUM1 = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_QUANTUM2 = 2'd2;

	// Operation codes of a request.
	localparam logic OP_ADD  = 1'b0;
	localparam logic OP_TICK = 1'b1;

	typedef logic [LEVEL_W-1:0] level_t;
	typedef logic [QUANT_W-1:0] quant_t;
	typedef logic [TASK_W-1:0]  task_id_t;

	typedef struct packed {
		logic     op;
		task_id_t task_id;
		level_t   add_level;
	} req_t;

	typedef struct packed {
		logic              scheduled;
		task_id_t          sel_task;
		level_t            from_level;
		quant_t            ran_ticks;
		quant_t            slice_left;
		level_t            to_level;
		logic              demoted;
		logic [WORD_W-1:0] task_total;
		logic [WORD_W-1:0] clock_now;
		logic              add_dropped;
	} rsp_t;

endpackage

`default_nettype wire

@@ design/mlfq_ram.sv @@
// Generic single-port-write, single-port-read RAM with a registered read.
// A read of the address being written returns the old contents.
// It is self-contained and uses no package.
`default_nettype none

module mlfq_ram #(
	parameter int WIDTH = 4,
	parameter int DEPTH = 48
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

@@ design/mlfq_scheduler_tick.sv @@
// Top level of the multilevel feedback queue scheduler.
// Depends on mlfq_pkg for types and constants and on mlfq_ram for the queue store.
//
// Channel   Direction  Handshake              Payload
// req       in         req_valid / req_ready  mlfq_pkg::req_t (op, task_id, add_level)
// rsp       out        rsp_valid / rsp_ready  mlfq_pkg::rsp_t (one result per request)
// cfg       in         cfg_we                 cfg_idx, cfg_data (quantum per level)
//
// Each accepted request is held in stage one and then registered into the result register,
// and one request can be taken every cycle while the result register is free or being emptied.
// The queue head is read from the queue RAM at the edge of acceptance, and the update of
// counts, slices and totals follows when stage one moves into the result register.
// After reset all queues are empty and every run total and the clock are zero.
// There is no clearing pass. When the result is not taken, the result register and the stage
// behind it hold; a new request is taken while that stage is empty or moving.
`default_nettype none

module mlfq_scheduler_tick (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             req_valid,
	output logic                                  req_ready,
	input  wire mlfq_pkg::req_t                   req,
	output logic                                  rsp_valid,
	input  wire logic                             rsp_ready,
	output mlfq_pkg::rsp_t                        rsp,
	input  wire logic                             cfg_we,
	input  wire logic [mlfq_pkg::CFG_IDX_W-1:0]   cfg_idx,
	input  wire logic [mlfq_pkg::QUANT_W-1:0]     cfg_data
);

	localparam mlfq_pkg::level_t LAST_LEVEL = mlfq_pkg::LEVEL_W'(mlfq_pkg::NUM_LEVELS - 1);
	localparam logic [mlfq_pkg::CNT_W-1:0] FULL_COUNT = mlfq_pkg::CNT_W'(mlfq_pkg::MAX_TASKS);

	// Configuration registers.
	mlfq_pkg::quant_t quant0_q;
	mlfq_pkg::quant_t quant1_q;
	mlfq_pkg::quant_t quant2_q;

	// Scheduler state.
	logic [mlfq_pkg::PTR_W-1:0]  head_q       [mlfq_pkg::NUM_LEVELS];
	logic [mlfq_pkg::CNT_W-1:0]  count_q      [mlfq_pkg::NUM_LEVELS];
	logic [mlfq_pkg::PTR_W-1:0]  head_d       [mlfq_pkg::NUM_LEVELS];
	logic [mlfq_pkg::CNT_W-1:0]  count_d      [mlfq_pkg::NUM_LEVELS];
	mlfq_pkg::quant_t            task_slice_q [mlfq_pkg::MAX_TASKS];
	logic [mlfq_pkg::WORD_W-1:0] task_total_q [mlfq_pkg::MAX_TASKS];
	logic [mlfq_pkg::WORD_W-1:0] clock_q;
	logic [mlfq_pkg::WORD_W-1:0] clock_d;

	// Stage one: the accepted request and what was learnt at acceptance.
	logic                    s1_valid_q;
	mlfq_pkg::req_t          req_s1;
	mlfq_pkg::level_t        lvl_s1;
	logic                    none_s1;
	logic                    fwd_s1;
	mlfq_pkg::task_id_t      fwd_data_s1;

	// Result register.
	logic                    rsp_valid_q;
	mlfq_pkg::rsp_t          rsp_q;
	mlfq_pkg::rsp_t          rsp_d;

	// Handshake control.
	logic                    s1_adv;
	logic                    s1_fire;
	logic                    req_accept;

	// Queue RAM ports.
	logic                        ram_we;
	logic [mlfq_pkg::RAM_AW-1:0] ram_waddr;
	mlfq_pkg::task_id_t          ram_wdata;
	logic                        ram_re;
	logic [mlfq_pkg::RAM_AW-1:0] ram_raddr;
	mlfq_pkg::task_id_t          ram_rdata;

	// Level choice for the incoming request.
	mlfq_pkg::level_t        pick_lvl;
	logic                    pick_found;
	logic                    fwd_d;

	// Stage one working signals.
	mlfq_pkg::level_t           add_idx;
	logic                       add_ok;
	mlfq_pkg::task_id_t         sel_task;
	logic [mlfq_pkg::PTR_W-1:0] sel_idx;
	mlfq_pkg::quant_t           q_cur;
	mlfq_pkg::quant_t           slice_cur;
	mlfq_pkg::quant_t           run;
	mlfq_pkg::quant_t           rem;
	logic                       exhausted;
	mlfq_pkg::level_t           lvl_up;
	logic                       can_demote;
	mlfq_pkg::level_t           dest;
	mlfq_pkg::quant_t           slice_new;
	logic [mlfq_pkg::WORD_W-1:0] total_new;
	mlfq_pkg::level_t           push_lvl;
	logic [mlfq_pkg::PTR_W-1:0] tail_pos;
	logic                       slice_we;
	logic [mlfq_pkg::PTR_W-1:0] slice_widx;
	mlfq_pkg::quant_t           slice_wdata;
	logic                       total_we;

	// Quantum of a level; the last level's quantum also serves any deeper level.
	function automatic mlfq_pkg::quant_t quantum_of(input mlfq_pkg::level_t lvl,
			input mlfq_pkg::quant_t q0, input mlfq_pkg::quant_t q1,
			input mlfq_pkg::quant_t q2);
		mlfq_pkg::quant_t q;
		case (lvl)
			2'd0: q = q0;
			2'd1: q = q1;
			default: q = q2;
		endcase
		return q;
	endfunction

	// Address of a slot of a level's queue in the shared RAM.
	function automatic logic [mlfq_pkg::RAM_AW-1:0] fifo_addr(input mlfq_pkg::level_t lvl,
			input logic [mlfq_pkg::PTR_W-1:0] pos);
		return mlfq_pkg::RAM_AW'(lvl) * mlfq_pkg::RAM_AW'(mlfq_pkg::MAX_TASKS)
			+ mlfq_pkg::RAM_AW'(pos);
	endfunction

	// Handshake: stage one moves when the result register is free or being emptied.
	assign s1_adv     = !rsp_valid_q || rsp_ready;
	assign s1_fire    = s1_valid_q && s1_adv;
	assign req_ready  = !s1_valid_q || s1_adv;
	assign req_accept = req_valid && req_ready;
	assign rsp_valid  = rsp_valid_q;
	assign rsp        = rsp_q;

	// Stage one decode of the task and its slice arithmetic.
	always_comb begin
		add_idx = (req_s1.add_level < mlfq_pkg::LEVEL_W'(mlfq_pkg::NUM_LEVELS))
			? req_s1.add_level : '0;
		add_ok = (req_s1.add_level < mlfq_pkg::LEVEL_W'(mlfq_pkg::NUM_LEVELS))
			&& (count_q[add_idx] != FULL_COUNT);
		sel_task   = fwd_s1 ? fwd_data_s1 : ram_rdata;
		sel_idx    = sel_task[mlfq_pkg::PTR_W-1:0];
		q_cur      = quantum_of(lvl_s1, quant0_q, quant1_q, quant2_q);
		slice_cur  = task_slice_q[sel_idx];
		run        = (slice_cur < q_cur) ? slice_cur : q_cur;
		rem        = slice_cur - run;
		exhausted  = (rem == '0);
		lvl_up     = (lvl_s1 == LAST_LEVEL) ? lvl_s1 : lvl_s1 + 1'b1;
		can_demote = (lvl_s1 != LAST_LEVEL) && (count_q[lvl_up] != FULL_COUNT);
		dest       = (exhausted && can_demote) ? lvl_up : lvl_s1;
		slice_new  = exhausted ? quantum_of(dest, quant0_q, quant1_q, quant2_q) : rem;
		total_new  = task_total_q[sel_idx] + mlfq_pkg::WORD_W'(run);
		// The tail of a level is the same before and after its own head is popped.
		push_lvl   = (req_s1.op == mlfq_pkg::OP_TICK) ? dest : add_idx;
		tail_pos   = head_q[push_lvl] + count_q[push_lvl][mlfq_pkg::PTR_W-1:0];
	end

	// Stage one state update and result formation.
	always_comb begin
		head_d      = head_q;
		count_d     = count_q;
		clock_d     = clock_q;
		ram_we      = 1'b0;
		ram_waddr   = '0;
		ram_wdata   = '0;
		slice_we    = 1'b0;
		slice_widx  = '0;
		slice_wdata = '0;
		total_we    = 1'b0;
		rsp_d       = '0;
		rsp_d.clock_now = clock_q;
		if (s1_fire) begin
			if (req_s1.op == mlfq_pkg::OP_ADD) begin
				rsp_d.add_dropped = !add_ok;
				if (add_ok) begin
					ram_we           = 1'b1;
					ram_waddr        = fifo_addr(add_idx, tail_pos);
					ram_wdata        = req_s1.task_id;
					count_d[add_idx] = count_q[add_idx] + 1'b1;
					slice_we         = 1'b1;
					slice_widx       = req_s1.task_id[mlfq_pkg::PTR_W-1:0];
					slice_wdata      = quantum_of(add_idx, quant0_q, quant1_q, quant2_q);
				end
			end else if (!none_s1) begin
				head_d[lvl_s1]  = head_q[lvl_s1] + 1'b1;
				count_d[lvl_s1] = count_q[lvl_s1] - 1'b1;
				count_d[dest]   = count_d[dest] + 1'b1;
				ram_we          = 1'b1;
				ram_waddr       = fifo_addr(dest, tail_pos);
				ram_wdata       = sel_task;
				slice_we        = 1'b1;
				slice_widx      = sel_idx;
				slice_wdata     = slice_new;
				total_we        = 1'b1;
				clock_d         = clock_q + mlfq_pkg::WORD_W'(run);
				rsp_d.scheduled  = 1'b1;
				rsp_d.sel_task   = sel_task;
				rsp_d.from_level = lvl_s1;
				rsp_d.ran_ticks  = run;
				rsp_d.slice_left = slice_new;
				rsp_d.to_level   = dest;
				rsp_d.demoted    = exhausted;
				rsp_d.task_total = total_new;
				rsp_d.clock_now  = clock_d;
			end
		end
	end

	// Highest non-empty level as it stands once stage one has finished.
	always_comb begin
		pick_lvl   = '0;
		pick_found = 1'b0;
		for (int i = mlfq_pkg::NUM_LEVELS - 1; i >= 0; i--) begin
			if (count_d[i] != '0) begin
				pick_lvl   = mlfq_pkg::LEVEL_W'(i);
				pick_found = 1'b1;
			end
		end
	end

	// Head read for a tick, with a bypass when stage one writes the same slot.
	assign ram_re    = req_accept && (req.op == mlfq_pkg::OP_TICK);
	assign ram_raddr = fifo_addr(pick_lvl, head_d[pick_lvl]);
	assign fwd_d     = ram_we && (ram_waddr == ram_raddr);

	mlfq_ram #(
		.WIDTH(mlfq_pkg::TASK_W),
		.DEPTH(mlfq_pkg::RAM_DEPTH)
	) u_queue_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quant0_q <= mlfq_pkg::QUANT_W'(2);
			quant1_q <= mlfq_pkg::QUANT_W'(4);
			quant2_q <= mlfq_pkg::QUANT_W'(8);
		end else if (cfg_we) begin
			case (cfg_idx)
				mlfq_pkg::REG_QUANTUM0: quant0_q <= cfg_data;
				mlfq_pkg::REG_QUANTUM1: quant1_q <= cfg_data;
				mlfq_pkg::REG_QUANTUM2: quant2_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Queue pointers, run totals, clock and the valid flags.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q  <= 1'b0;
			rsp_valid_q <= 1'b0;
			clock_q     <= '0;
			for (int i = 0; i < mlfq_pkg::NUM_LEVELS; i++) begin
				head_q[i]  <= '0;
				count_q[i] <= '0;
			end
			for (int i = 0; i < mlfq_pkg::MAX_TASKS; i++) begin
				task_total_q[i] <= '0;
			end
		end else begin
			head_q  <= head_d;
			count_q <= count_d;
			clock_q <= clock_d;
			if (total_we) begin
				task_total_q[sel_idx] <= total_new;
			end
			if (req_accept) begin
				s1_valid_q <= 1'b1;
			end else if (s1_fire) begin
				s1_valid_q <= 1'b0;
			end
			if (s1_fire) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers: stage one, result and the per-task slices.
	always_ff @(posedge clk) begin
		if (req_accept) begin
			req_s1      <= req;
			lvl_s1      <= pick_lvl;
			none_s1     <= !pick_found;
			fwd_s1      <= fwd_d;
			fwd_data_s1 <= ram_wdata;
		end
		if (s1_fire) begin
			rsp_q <= rsp_d;
		end
		if (slice_we) begin
			task_slice_q[slice_widx] <= slice_wdata;
		end
	end

	// A level never holds more tasks than its queue has slots.
	for (genvar g = 0; g < mlfq_pkg::NUM_LEVELS; g++) begin : g_cnt_chk
		a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
			count_q[g] <= FULL_COUNT)
			else $error("queue fill count exceeds its depth");
	end

	// Every request leaving stage one shows up in the result register next cycle.
	a_stage_to_rsp: assert property (@(posedge clk) disable iff (!arst_n)
		s1_fire |=> rsp_valid_q)
		else $error("stage one result was lost");

	// A refused add never reports a scheduled task.
	a_drop_only_add: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q && rsp_q.add_dropped |-> !rsp_q.scheduled)
		else $error("dropped add reported as scheduled");

	// A task that keeps slice stays on its level; a demotion moves at most one level down.
	a_level_move: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q && rsp_q.scheduled |->
			(!rsp_q.demoted && rsp_q.to_level == rsp_q.from_level
				&& rsp_q.slice_left != '0)
			|| (rsp_q.demoted && (rsp_q.to_level == rsp_q.from_level
				|| rsp_q.to_level == rsp_q.from_level + 1'b1)))
		else $error("task placed on an unexpected level");

	// A task taken off a queue by a tick is always written back to a queue.
	a_tick_keeps_task: assert property (@(posedge clk) disable iff (!arst_n)
		s1_fire && req_s1.op == mlfq_pkg::OP_TICK && !none_s1 |-> ram_we)
		else $error("scheduled task was not requeued");

endmodule

`default_nettype wire

@@ test/mlfq_sched_checker.sv @@
`timescale 1ns / 1ps
// Result checker for the multilevel feedback queue scheduler: it watches the request, result and
// configuration ports, keeps its own copy of the queues and predicts every result in order.
// Depends on mlfq_pkg for the request and result structs, the sizing and the register indexes.

module mlfq_sched_checker (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           req_valid,
	input  wire logic                           req_ready,
	input  wire mlfq_pkg::req_t                 req,
	input  wire logic                           rsp_valid,
	input  wire logic                           rsp_ready,
	input  wire mlfq_pkg::rsp_t                 rsp,
	input  wire logic                           cfg_we,
	input  wire logic [mlfq_pkg::CFG_IDX_W-1:0] cfg_idx,
	input  wire logic [mlfq_pkg::QUANT_W-1:0]   cfg_data,
	output int                                  mismatches,
	output int                                  awaiting,
	output int                                  ran_count,
	output int                                  demote_count,
	output int                                  refused_count
);
	import mlfq_pkg::*;

	localparam int MAX_PRINTED = 100;

	// Shadow copy of the scheduler state.
	task_id_t          queue_store [NUM_LEVELS][MAX_TASKS];
	logic [PTR_W-1:0]  q_head [NUM_LEVELS];
	logic [CNT_W-1:0]  q_fill [NUM_LEVELS];
	quant_t            slice_of [MAX_TASKS];
	logic [WORD_W-1:0] run_total [MAX_TASKS];
	logic [WORD_W-1:0] sys_time;
	quant_t            quantum [NUM_LEVELS];

	// Results predicted but not yet seen on the result port, oldest first.
	rsp_t expected_results [$];
	int   result_index;

	// Prints one line for a mismatch and counts it.
	task automatic flag_mismatch(input string what, input logic [WORD_W-1:0] got,
			input logic [WORD_W-1:0] want);
		if (mismatches < MAX_PRINTED) begin
			$display("%0t ns: result %0d, %s: got 0x%0h, expected 0x%0h",
				$time, result_index, what, got, want);
		end
		mismatches++;
	endtask

	// Puts a task id at the tail of a level.
	function automatic void enqueue_task(input int lvl, input task_id_t id);
		int pos;
		pos = (q_head[lvl] + q_fill[lvl]) % MAX_TASKS;
		queue_store[lvl][pos] = id;
		q_fill[lvl] = q_fill[lvl] + 1'b1;
	endfunction

	// Applies one request to the shadow state and returns the result it should give.
	function automatic rsp_t schedule_step(input req_t item);
		rsp_t     res;
		int       lvl;
		int       dest;
		task_id_t sel;
		quant_t   ran;
		quant_t   left;
		res = '0;
		if (item.op == OP_ADD) begin
			if (int'(item.add_level) >= NUM_LEVELS) begin
				res.add_dropped = 1'b1;
			end else if (q_fill[item.add_level] >= MAX_TASKS) begin
				res.add_dropped = 1'b1;
			end else begin
				slice_of[item.task_id] = quantum[item.add_level];
				enqueue_task(int'(item.add_level), item.task_id);
			end
			res.clock_now = sys_time;
			return res;
		end

		// A tick serves the highest level that holds anything.
		lvl = NUM_LEVELS;
		for (int i = NUM_LEVELS - 1; i >= 0; i--) begin
			if (q_fill[i] != 0) lvl = i;
		end
		if (lvl == NUM_LEVELS) begin
			res.clock_now = sys_time;
			return res;
		end

		sel = queue_store[lvl][q_head[lvl]];
		q_head[lvl] = PTR_W'((q_head[lvl] + 1) % MAX_TASKS);
		q_fill[lvl] = q_fill[lvl] - 1'b1;

		// Run for the shorter of the remaining slice and the level's quantum.
		ran = (slice_of[sel] < quantum[lvl]) ? slice_of[sel] : quantum[lvl];
		left = slice_of[sel] - ran;
		sys_time += ran;
		run_total[sel] += ran;
		res.demoted = (left == 0);

		// An exhausted task drops a level unless that level is full or it is already at the
		// bottom; either way its slice is reloaded from the level it lands in.
		dest = lvl;
		if (left == 0) begin
			if (lvl + 1 < NUM_LEVELS) begin
				if (q_fill[lvl + 1] < MAX_TASKS) dest = lvl + 1;
			end
			left = quantum[dest];
		end
		slice_of[sel] = left;
		enqueue_task(dest, sel);

		res.scheduled  = 1'b1;
		res.sel_task   = sel;
		res.from_level = level_t'(lvl);
		res.ran_ticks  = ran;
		res.slice_left = left;
		res.to_level   = level_t'(dest);
		res.task_total = run_total[sel];
		res.clock_now  = sys_time;
		return res;
	endfunction

	// Track configuration writes, predict each accepted request and check each result.
	always @(posedge clk or negedge arst_n) begin
		rsp_t want;
		if (!arst_n) begin
			for (int i = 0; i < NUM_LEVELS; i++) begin
				q_head[i] = '0;
				q_fill[i] = '0;
			end
			for (int i = 0; i < MAX_TASKS; i++) begin
				run_total[i] = '0;
				slice_of[i] = '0;
			end
			sys_time = '0;
			quantum[0] = 8'd2;
			quantum[1] = 8'd4;
			quantum[2] = 8'd8;
			expected_results.delete();
			result_index = 0;
			mismatches = 0;
			ran_count = 0;
			demote_count = 0;
			refused_count = 0;
			awaiting <= 0;
		end else begin
			if (cfg_we) begin
				case (cfg_idx)
					REG_QUANTUM0: quantum[0] = cfg_data;
					REG_QUANTUM1: quantum[1] = cfg_data;
					REG_QUANTUM2: quantum[2] = cfg_data;
					default: ;
				endcase
			end

			if (req_valid && req_ready) begin
				want = schedule_step(req);
				ran_count += want.scheduled;
				demote_count += want.demoted;
				refused_count += want.add_dropped;
				expected_results.push_back(want);
			end

			if (rsp_valid && rsp_ready) begin
				if (expected_results.size() == 0) begin
					flag_mismatch("result with no request outstanding", WORD_W'(rsp), '0);
				end else begin
					want = expected_results.pop_front();
					if (rsp.scheduled !== want.scheduled)
						flag_mismatch("scheduled", rsp.scheduled, want.scheduled);
					if (rsp.sel_task !== want.sel_task)
						flag_mismatch("sel_task", rsp.sel_task, want.sel_task);
					if (rsp.from_level !== want.from_level)
						flag_mismatch("from_level", rsp.from_level, want.from_level);
					if (rsp.ran_ticks !== want.ran_ticks)
						flag_mismatch("ran_ticks", rsp.ran_ticks, want.ran_ticks);
					if (rsp.slice_left !== want.slice_left)
						flag_mismatch("slice_left", rsp.slice_left, want.slice_left);
					if (rsp.to_level !== want.to_level)
						flag_mismatch("to_level", rsp.to_level, want.to_level);
					if (rsp.demoted !== want.demoted)
						flag_mismatch("demoted", rsp.demoted, want.demoted);
					if (rsp.task_total !== want.task_total)
						flag_mismatch("task_total", rsp.task_total, want.task_total);
					if (rsp.clock_now !== want.clock_now)
						flag_mismatch("clock_now", rsp.clock_now, want.clock_now);
					if (rsp.add_dropped !== want.add_dropped)
						flag_mismatch("add_dropped", rsp.add_dropped, want.add_dropped);
				end
				result_index++;
			end

			// Sampled by the stimulus only after the edge, so it is driven late.
			awaiting <= expected_results.size();
		end
	end

endmodule

@@ test/tb_mlfq_scheduler_tick.sv @@
`timescale 1ns / 1ps
// Top of the scheduler testbench: clock, reset, request and configuration stimulus, random
// back-pressure on the result port and the final verdict.
// Depends on mlfq_pkg, on the block mlfq_scheduler_tick and on the checker mlfq_sched_checker.

module tb_mlfq_scheduler_tick;
	import mlfq_pkg::*;

	localparam int CYCLE_LIMIT    = 1_000_000;
	localparam int PHASE_REQUESTS = 400;
	localparam int NUM_PHASES     = 5;
	localparam int SETTLE_CYCLES  = 4;

	// Index with no register behind it; a write there must change nothing.
	localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

	logic                 clk;
	logic                 arst_n;
	logic                 req_valid;
	logic                 req_ready;
	req_t                 req;
	logic                 rsp_valid;
	logic                 rsp_ready;
	rsp_t                 rsp;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_idx;
	quant_t               cfg_data;

	int mismatches;
	int awaiting;
	int ran_count;
	int demote_count;
	int refused_count;
	int cycle_count = 0;
	int requests_sent = 0;
	bit steady = 1'b0;

	mlfq_scheduler_tick dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_data  (cfg_data)
	);

	mlfq_sched_checker result_check (
		.clk           (clk),
		.arst_n        (arst_n),
		.req_valid     (req_valid),
		.req_ready     (req_ready),
		.req           (req),
		.rsp_valid     (rsp_valid),
		.rsp_ready     (rsp_ready),
		.rsp           (rsp),
		.cfg_we        (cfg_we),
		.cfg_idx       (cfg_idx),
		.cfg_data      (cfg_data),
		.mismatches    (mismatches),
		.awaiting      (awaiting),
		.ran_count     (ran_count),
		.demote_count  (demote_count),
		.refused_count (refused_count)
	);

	// Clock with a 20 ns period.
	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Hard stop in case the block hangs.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	// Idle length for either side: mostly none or short, now and then long.
	function automatic int idle_gap();
		int roll;
		if (steady) return 0;
		roll = $urandom_range(0, 99);
		if (roll < 45) return 0;
		if (roll < 85) return $urandom_range(1, 3);
		if (roll < 97) return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// Random back-pressure on the result port.
	initial begin
		int gap;
		rsp_ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			gap = idle_gap();
			if (gap > 0) begin
				rsp_ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			rsp_ready <= 1'b1;
			repeat ($urandom_range(1, 24)) @(posedge clk);
		end
	end

	// Presents one request after an optional gap and holds it until it is taken.
	task automatic issue(input logic op_code, input task_id_t id, input level_t lvl);
		req_t item;
		int   gap;
		item.op = op_code;
		item.task_id = id;
		item.add_level = lvl;
		gap = idle_gap();
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_valid <= 1'b1;
		req <= item;
		do @(posedge clk); while (!req_ready);
		requests_sent++;
	endtask

	// Mostly ticks; adds pick any task and now and then a level that does not exist.
	task automatic random_request();
		logic     op_code;
		task_id_t id;
		level_t   lvl;
		op_code = ($urandom_range(0, 99) < 30) ? OP_ADD : OP_TICK;
		id = task_id_t'($urandom_range(0, MAX_TASKS - 1));
		if ($urandom_range(0, 19) == 0)
			lvl = level_t'(NUM_LEVELS);
		else
			lvl = level_t'($urandom_range(0, NUM_LEVELS - 1));
		issue(op_code, id, lvl);
	endtask

	// Stops sending and waits until every outstanding result has come back.
	task automatic drain();
		req_valid <= 1'b0;
		@(posedge clk);
		while (awaiting != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Writes all three quanta, plus a write to the unused index.
	task automatic program_quanta(input quant_t q0, input quant_t q1, input quant_t q2);
		cfg_we <= 1'b1;
		cfg_idx <= REG_QUANTUM0;
		cfg_data <= q0;
		@(posedge clk);
		cfg_idx <= REG_QUANTUM1;
		cfg_data <= q1;
		@(posedge clk);
		cfg_idx <= REG_QUANTUM2;
		cfg_data <= q2;
		@(posedge clk);
		cfg_idx <= REG_SPARE;
		cfg_data <= quant_t'($urandom_range(0, 255));
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// Main stimulus.
	initial begin
		arst_n <= 1'b0;
		req_valid <= 1'b0;
		req <= '0;
		cfg_we <= 1'b0;
		cfg_idx <= REG_QUANTUM0;
		cfg_data <= '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part, with the reset quanta.
		// A tick with every queue empty.
		issue(OP_TICK, 4'hF, 2'd3);
		// An add to a level that does not exist.
		issue(OP_ADD, 4'h0, level_t'(NUM_LEVELS));
		// Fill the middle level, then one more add that must be refused.
		for (int i = 0; i < MAX_TASKS; i++) begin
			issue(OP_ADD, task_id_t'(i), 2'd1);
		end
		issue(OP_ADD, 4'h5, 2'd1);
		// Same id again at the top level: it shares its slice with the copy below.
		issue(OP_ADD, 4'hF, 2'd0);
		// Its slice runs out but the level below is full, so it stays where it is.
		issue(OP_TICK, 4'h0, 2'd0);
		issue(OP_TICK, 4'hA, 2'd2);
		issue(OP_ADD, 4'h9, 2'd2);
		issue(OP_TICK, 4'h3, 2'd1);
		issue(OP_TICK, 4'hC, 2'd3);

		// Random phases, each with its own quanta.
		for (int phase = 0; phase < NUM_PHASES; phase++) begin
			if (phase > 0) begin
				drain();
				case (phase)
					1: program_quanta(8'd255, 8'd255, 8'd255);
					// Much smaller than the slices left over from the previous phase.
					2: program_quanta(8'd1, 8'd2, 8'd3);
					// A zero quantum at the top level.
					3: program_quanta(8'd0, 8'd1, 8'd255);
					default: program_quanta(quant_t'($urandom_range(0, 255)),
						quant_t'($urandom_range(0, 255)), quant_t'($urandom_range(0, 255)));
				endcase
			end
			steady = (phase == 1);
			repeat (PHASE_REQUESTS) random_request();
		end
		drain();

		$display("Sent %0d requests over %0d quantum settings: %0d ticks ran a task,",
			requests_sent, NUM_PHASES, ran_count);
		$display("%0d of them used up their slice, and %0d adds were refused.",
			demote_count, refused_count);
		if (mismatches == 0 && awaiting == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule
